// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pds_pkg.sv -----
// ----------------------------------------------------------------------------
// pds_pkg
// Shared constants, codes and types of the Poisson disk sampler.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int GRID_SIDE      = 64;
  localparam int MAX_SAMPLES    = 4096;
  localparam int NEIGHBOR_RANGE = 2;

  localparam int SIDE_W    = $clog2(GRID_SIDE);
  localparam int CELL_AW   = 2 * SIDE_W;
  localparam int SAMPLE_AW = $clog2(MAX_SAMPLES);
  localparam int CNT_W     = SAMPLE_AW + 1;
  localparam int CELL_DW   = SAMPLE_AW + 1;
  localparam int NB_W      = 3;

  // result status codes
  localparam logic [2:0] ST_SEEDED   = 3'd0;
  localparam logic [2:0] ST_PLACED   = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_OUTSIDE  = 3'd3;
  localparam logic [2:0] ST_RETIRED  = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  // register indexes
  localparam logic [2:0] REG_COLS    = 3'd0;
  localparam logic [2:0] REG_ROWS    = 3'd1;
  localparam logic [2:0] REG_RADIUS2 = 3'd2;
  localparam logic [2:0] REG_INVCELL = 3'd3;
  localparam logic [2:0] REG_TRIES   = 3'd4;

  // datapath commands
  localparam logic [4:0] CMD_NOP        = 5'd0;
  localparam logic [4:0] CMD_CLR        = 5'd1;
  localparam logic [4:0] CMD_LATCH      = 5'd2;
  localparam logic [4:0] CMD_LOC_SEED   = 5'd3;
  localparam logic [4:0] CMD_RD_OWN     = 5'd4;
  localparam logic [4:0] CMD_STORE_SEED = 5'd5;
  localparam logic [4:0] CMD_REJECT     = 5'd6;
  localparam logic [4:0] CMD_OUTSIDE    = 5'd7;
  localparam logic [4:0] CMD_DONE       = 5'd8;
  localparam logic [4:0] CMD_PICK       = 5'd9;
  localparam logic [4:0] CMD_RD_ACT     = 5'd10;
  localparam logic [4:0] CMD_RD_BASE    = 5'd11;
  localparam logic [4:0] CMD_LOAD_BASE  = 5'd12;
  localparam logic [4:0] CMD_LOC_CAND   = 5'd13;
  localparam logic [4:0] CMD_SCAN_INIT  = 5'd14;
  localparam logic [4:0] CMD_N_READ     = 5'd15;
  localparam logic [4:0] CMD_N_OWNER    = 5'd16;
  localparam logic [4:0] CMD_SQUARE     = 5'd17;
  localparam logic [4:0] CMD_ADV        = 5'd18;
  localparam logic [4:0] CMD_STORE_CAND = 5'd19;
  localparam logic [4:0] CMD_TRY_FAIL   = 5'd20;
  localparam logic [4:0] CMD_SHIFT_INIT = 5'd21;
  localparam logic [4:0] CMD_SHIFT_RD   = 5'd22;
  localparam logic [4:0] CMD_SHIFT_WR   = 5'd23;
  localparam logic [4:0] CMD_RETIRE     = 5'd24;
  localparam logic [4:0] CMD_EMIT       = 5'd25;

  typedef struct packed {
    logic [6:0]  cols;
    logic [6:0]  rows;
    logic [31:0] radius2;
    logic [15:0] inv_cell;
    logic [6:0]  tries;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic [15:0]        point_x;
    logic [15:0]        point_y;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [15:0]        pick_fraction;
  } item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      from_x;
    logic [15:0]      from_y;
    logic [15:0]      to_x;
    logic [15:0]      to_y;
    logic [CNT_W-1:0] samples_stored;
    logic [CNT_W-1:0] active_remaining;
  } result_t;

  typedef struct packed {
    logic mode;
    logic act_zero;
    logic need_pick;
    logic in_grid;
    logic full;
    logic cell_valid;
    logic nb_in;
    logic own;
    logic close;
    logic scan_last;
    logic retire_due;
    logic shift_more;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/pds_if.sv -----
// ----------------------------------------------------------------------------
// pds_in_if / pds_out_if
// Valid/ready channels carrying the input item and the result item.
// ----------------------------------------------------------------------------
interface pds_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [15:0]        point_x;
  logic [15:0]        point_y;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic [15:0]        pick_fraction;

  modport source (output valid, mode, point_x, point_y, offset_x, offset_y,
                  pick_fraction, input ready);
  modport sink (input valid, mode, point_x, point_y, offset_x, offset_y,
                pick_fraction, output ready);
endinterface

interface pds_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] from_x;
  logic [15:0] from_y;
  logic [15:0] to_x;
  logic [15:0] to_y;
  logic [12:0] samples_stored;
  logic [12:0] active_remaining;

  modport source (output valid, status, from_x, from_y, to_x, to_y, samples_stored,
                  active_remaining, input ready);
  modport sink (input valid, status, from_x, from_y, to_x, to_y, samples_stored,
                active_remaining, output ready);
endinterface

// ----- rtl/core/poisson_disk_sampler_top.sv -----
// ----------------------------------------------------------------------------
// poisson_disk_sampler_top
// Poisson disk sampler on a 64x64 background grid, up to 4096 samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one beat per random draw: mode 0 places the seed point
//   (point_x/y), mode 1 tries a candidate offset (offset_x/y) from the open
//   base sample, pick_fraction choosing that base when a new step opens.
//   out_ch returns exactly one result beat per input beat, in order. The user
//   writes APB port registers only while idle; the block does not enforce it.
// Flow: one item at a time. A seed is located, its cell read, then stored
//   or rejected and handed off. A candidate reads its base slot from the
//   active list and the base from the sample memory, forms and locates the
//   point, then visits each of the 25 neighbor cells (off grid skipped,
//   empty read, with a sample: cell read, sample read, square, compare),
//   then is stored and handed off. Retiring a base shifts the active list
//   down through one memory port, entry by entry behind the removed slot.
// Reset: rst clears counters and then runs a pass that empties the cell
//   memory; in_ch.ready stays low until it ends.
// Stall: a result held on out_ch blocks only the hand-off of the next
//   result; the next item is still accepted and processed meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module poisson_disk_sampler_top (
  input  logic        clk,
  input  logic        rst,
  pds_in_if.sink      in_ch,
  pds_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pds_pkg::cfg_t       cfg;
  pds_pkg::item_t      item;
  pds_pkg::dp_status_t st;
  pds_pkg::result_t    res;
  logic [4:0]          cmd;
  logic [2:0]          reg_idx;
  logic                cfg_wr;

  // config registers, one per word
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols     <= 7'd64;
      cfg.rows     <= 7'd64;
      cfg.radius2  <= 32'd65536;
      cfg.inv_cell <= 16'd16384;
      cfg.tries    <= 7'd30;
    end else if (cfg_wr) begin
      case (reg_idx)
        pds_pkg::REG_COLS:    cfg.cols     <= pwdata[6:0];
        pds_pkg::REG_ROWS:    cfg.rows     <= pwdata[6:0];
        pds_pkg::REG_RADIUS2: cfg.radius2  <= pwdata;
        pds_pkg::REG_INVCELL: cfg.inv_cell <= pwdata[15:0];
        pds_pkg::REG_TRIES:   cfg.tries    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pds_pkg::REG_COLS:    prdata = {25'd0, cfg.cols};
      pds_pkg::REG_ROWS:    prdata = {25'd0, cfg.rows};
      pds_pkg::REG_RADIUS2: prdata = cfg.radius2;
      pds_pkg::REG_INVCELL: prdata = {16'd0, cfg.inv_cell};
      pds_pkg::REG_TRIES:   prdata = {25'd0, cfg.tries};
      default:              prdata = '0;
    endcase
  end

  // input beat
  assign item.mode          = in_ch.mode;
  assign item.point_x       = in_ch.point_x;
  assign item.point_y       = in_ch.point_y;
  assign item.offset_x      = in_ch.offset_x;
  assign item.offset_y      = in_ch.offset_y;
  assign item.pick_fraction = in_ch.pick_fraction;

  pds_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .st(st), .cmd(cmd)
  );

  pds_dp u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .item(item), .cmd(cmd), .st(st),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  // output beat
  assign out_ch.status           = res.status;
  assign out_ch.from_x           = res.from_x;
  assign out_ch.from_y           = res.from_y;
  assign out_ch.to_x             = res.to_x;
  assign out_ch.to_y             = res.to_y;
  assign out_ch.samples_stored   = res.samples_stored;
  assign out_ch.active_remaining = res.active_remaining;

  // checks
  `ASSERT_IMPL(a_active_le_stored, out_ch.valid, out_ch.active_remaining <= out_ch.samples_stored, "active list larger than sample store")
  `ASSERT_NEXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready, "second item taken while one is in work")
  `ASSERT_IMPL(a_seed_pair, out_ch.valid && out_ch.status == pds_pkg::ST_SEEDED, out_ch.from_x == out_ch.to_x && out_ch.from_y == out_ch.to_y, "seed result with differing points")

endmodule

// ----- rtl/core/pds_ram.sv -----
// ----------------------------------------------------------------------------
// pds_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module pds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/core/pds_ctrl.sv -----
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer: walks seed, pick, neighbor scan, retire shift and result hand-off.
// ----------------------------------------------------------------------------
module pds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pds_pkg::dp_status_t st,
  output logic [4:0]          cmd
);

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_DISPATCH  = 5'd2;
  localparam logic [4:0] S_SEED_CHK  = 5'd3;
  localparam logic [4:0] S_SEED_WAIT = 5'd4;
  localparam logic [4:0] S_BASE_RD   = 5'd5;
  localparam logic [4:0] S_BASE_WAIT = 5'd6;
  localparam logic [4:0] S_BASE_PT   = 5'd7;
  localparam logic [4:0] S_CAND_LOC  = 5'd8;
  localparam logic [4:0] S_CAND_CHK  = 5'd9;
  localparam logic [4:0] S_N_ADDR    = 5'd10;
  localparam logic [4:0] S_N_CELL    = 5'd11;
  localparam logic [4:0] S_N_SQ      = 5'd12;
  localparam logic [4:0] S_N_CMP     = 5'd13;
  localparam logic [4:0] S_PLACE     = 5'd14;
  localparam logic [4:0] S_FAIL      = 5'd15;
  localparam logic [4:0] S_SHIFT_RD  = 5'd16;
  localparam logic [4:0] S_SHIFT_WR  = 5'd17;
  localparam logic [4:0] S_FIN       = 5'd18;

  logic [4:0] state, state_next;
  logic [4:0] scan_step;

  // where the scan goes after the current neighbor passes
  assign scan_step = st.scan_last ? S_PLACE : S_N_ADDR;

  always_comb begin
    state_next = state;
    cmd        = pds_pkg::CMD_NOP;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd = pds_pkg::CMD_CLR;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = pds_pkg::CMD_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!st.mode) begin
          cmd        = pds_pkg::CMD_LOC_SEED;
          state_next = S_SEED_CHK;
        end else if (st.act_zero) begin
          cmd        = pds_pkg::CMD_DONE;
          state_next = S_FIN;
        end else begin
          if (st.need_pick) cmd = pds_pkg::CMD_PICK;
          state_next = S_BASE_RD;
        end
      end
      S_SEED_CHK: begin
        if (!st.in_grid) begin
          cmd        = pds_pkg::CMD_OUTSIDE;
          state_next = S_FIN;
        end else begin
          cmd        = pds_pkg::CMD_RD_OWN;
          state_next = S_SEED_WAIT;
        end
      end
      S_SEED_WAIT: begin
        cmd        = (st.cell_valid || st.full) ? pds_pkg::CMD_REJECT
                                                : pds_pkg::CMD_STORE_SEED;
        state_next = S_FIN;
      end
      S_BASE_RD: begin
        cmd        = pds_pkg::CMD_RD_ACT;
        state_next = S_BASE_WAIT;
      end
      S_BASE_WAIT: begin
        cmd        = pds_pkg::CMD_RD_BASE;
        state_next = S_BASE_PT;
      end
      S_BASE_PT: begin
        cmd        = pds_pkg::CMD_LOAD_BASE;
        state_next = S_CAND_LOC;
      end
      S_CAND_LOC: begin
        cmd        = pds_pkg::CMD_LOC_CAND;
        state_next = S_CAND_CHK;
      end
      S_CAND_CHK: begin
        if (!st.in_grid) begin
          cmd        = pds_pkg::CMD_OUTSIDE;
          state_next = S_FIN;
        end else if (st.full) begin
          state_next = S_FAIL;
        end else begin
          cmd        = pds_pkg::CMD_SCAN_INIT;
          state_next = S_N_ADDR;
        end
      end
      S_N_ADDR: begin
        if (st.nb_in) begin
          cmd        = pds_pkg::CMD_N_READ;
          state_next = S_N_CELL;
        end else begin
          cmd        = pds_pkg::CMD_ADV;
          state_next = scan_step;
        end
      end
      S_N_CELL: begin
        if (!st.cell_valid) begin
          cmd        = pds_pkg::CMD_ADV;
          state_next = scan_step;
        end else if (st.own) begin
          state_next = S_FAIL;
        end else begin
          cmd        = pds_pkg::CMD_N_OWNER;
          state_next = S_N_SQ;
        end
      end
      S_N_SQ: begin
        cmd        = pds_pkg::CMD_SQUARE;
        state_next = S_N_CMP;
      end
      S_N_CMP: begin
        if (st.close) begin
          state_next = S_FAIL;
        end else begin
          cmd        = pds_pkg::CMD_ADV;
          state_next = scan_step;
        end
      end
      S_PLACE: begin
        cmd        = pds_pkg::CMD_STORE_CAND;
        state_next = S_FIN;
      end
      S_FAIL: begin
        if (st.retire_due) begin
          cmd        = pds_pkg::CMD_SHIFT_INIT;
          state_next = S_SHIFT_RD;
        end else begin
          cmd        = pds_pkg::CMD_TRY_FAIL;
          state_next = S_FIN;
        end
      end
      S_SHIFT_RD: begin
        if (st.shift_more) begin
          cmd        = pds_pkg::CMD_SHIFT_RD;
          state_next = S_SHIFT_WR;
        end else begin
          cmd        = pds_pkg::CMD_RETIRE;
          state_next = S_FIN;
        end
      end
      S_SHIFT_WR: begin
        cmd        = pds_pkg::CMD_SHIFT_WR;
        state_next = S_SHIFT_RD;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd        = pds_pkg::CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/pds_dp.sv -----
// ----------------------------------------------------------------------------
// pds_dp
// Datapath: counters, cell/sample/active memories, locate, distance, result.
// ----------------------------------------------------------------------------
module pds_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  pds_pkg::cfg_t        cfg,
  input  pds_pkg::item_t       item,
  input  logic [4:0]           cmd,
  output pds_pkg::dp_status_t  st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pds_pkg::result_t     out_res
);

  localparam int SW = pds_pkg::SIDE_W;
  localparam int AW = pds_pkg::SAMPLE_AW;
  localparam int CW = pds_pkg::CNT_W;
  localparam int NW = pds_pkg::NB_W;
  localparam logic [SW:0]          SIDE_MAX = (SW+1)'(pds_pkg::GRID_SIDE);
  localparam logic [CW-1:0]        CAP      = CW'(pds_pkg::MAX_SAMPLES);
  localparam logic signed [NW-1:0] NB_MAX   = NW'(pds_pkg::NEIGHBOR_RANGE);
  localparam logic signed [NW-1:0] NB_MIN   = -NB_MAX;

  // control state
  logic [CW-1:0]        active_total, sample_total;
  logic [AW-1:0]        open_slot, shift_idx;
  logic [6:0]           failed;
  logic                 step_open;
  logic [pds_pkg::CELL_AW-1:0] clr_idx;

  // payload
  pds_pkg::item_t       it;
  logic [15:0]          pt_x, pt_y, bx, by;
  logic signed [17:0]   nx, ny;
  logic                 rng_bad;
  logic [9:0]           cxf, cyf;
  logic signed [NW-1:0] dx, dy;
  logic [31:0]          sq_x, sq_y;
  logic [2:0]           res_status;
  logic [15:0]          res_fx, res_fy, res_tx, res_ty;

  // memories
  logic [pds_pkg::CELL_AW-1:0] cell_addr;
  logic                        cell_we;
  logic [pds_pkg::CELL_DW-1:0] cell_wdata, cell_rdata;
  logic [AW-1:0]               smp_addr;
  logic                        smp_we;
  logic [31:0]                 smp_rdata;
  logic [AW-1:0]               act_addr;
  logic                        act_we;
  logic [AW-1:0]               act_wdata, act_rdata;

  logic [SW:0]          eff_cols, eff_rows;
  logic [15:0]          loc_x, loc_y;
  logic [31:0]          prod_x, prod_y;
  logic [SW-1:0]        cx, cy;
  logic signed [SW+1:0] ncx, ncy;
  logic [15:0]          adx, ady;
  logic [28:0]          pick_prod;
  logic [6:0]           failed_next;
  logic [CW-1:0]        shift_inc;
  logic                 storing;

  assign eff_cols = (cfg.cols > SIDE_MAX) ? SIDE_MAX : cfg.cols[SW:0];
  assign eff_rows = (cfg.rows > SIDE_MAX) ? SIDE_MAX : cfg.rows[SW:0];

  // point to cell: (c * inv) >> 22
  assign loc_x  = (cmd == pds_pkg::CMD_LOC_SEED) ? it.point_x : nx[15:0];
  assign loc_y  = (cmd == pds_pkg::CMD_LOC_SEED) ? it.point_y : ny[15:0];
  assign prod_x = {16'd0, loc_x} * {16'd0, cfg.inv_cell};
  assign prod_y = {16'd0, loc_y} * {16'd0, cfg.inv_cell};
  assign cx     = cxf[SW-1:0];
  assign cy     = cyf[SW-1:0];

  assign ncx = $signed({2'b00, cx}) + $signed({{(SW+2-NW){dx[NW-1]}}, dx});
  assign ncy = $signed({2'b00, cy}) + $signed({{(SW+2-NW){dy[NW-1]}}, dy});

  assign adx = (smp_rdata[31:16] >= pt_x) ? smp_rdata[31:16] - pt_x
                                          : pt_x - smp_rdata[31:16];
  assign ady = (smp_rdata[15:0] >= pt_y) ? smp_rdata[15:0] - pt_y
                                         : pt_y - smp_rdata[15:0];

  assign pick_prod   = {13'd0, it.pick_fraction} * {16'd0, active_total};
  assign failed_next = failed + 7'd1;
  assign shift_inc   = {1'b0, shift_idx} + CW'(1);
  assign storing     = (cmd == pds_pkg::CMD_STORE_SEED) || (cmd == pds_pkg::CMD_STORE_CAND);

  // status to the sequencer
  always_comb begin
    st.mode       = it.mode;
    st.act_zero   = (active_total == '0);
    st.need_pick  = !step_open || ({1'b0, open_slot} >= active_total);
    st.in_grid    = !rng_bad && (cxf < {3'b000, eff_cols}) && (cyf < {3'b000, eff_rows});
    st.full       = (sample_total >= CAP);
    st.cell_valid = cell_rdata[pds_pkg::CELL_DW-1];
    st.nb_in      = !ncx[SW+1] && !ncy[SW+1] &&
                    (ncx[SW:0] < eff_cols) && (ncy[SW:0] < eff_rows);
    st.own        = (dx == '0) && (dy == '0);
    st.close      = ({1'b0, sq_x} + {1'b0, sq_y}) <= {1'b0, cfg.radius2};
    st.scan_last  = (dx == NB_MAX) && (dy == NB_MAX);
    st.retire_due = (failed_next >= cfg.tries) || (failed_next == 7'd0);
    st.shift_more = (shift_inc < active_total);
    st.clr_last   = (clr_idx == '1);
    st.out_free   = !out_valid || out_ready;
  end

  // memory port muxes
  always_comb begin
    cell_addr  = {cy, cx};
    cell_we    = storing;
    cell_wdata = {1'b1, sample_total[AW-1:0]};
    if (cmd == pds_pkg::CMD_CLR) begin
      cell_addr  = clr_idx;
      cell_we    = 1'b1;
      cell_wdata = '0;
    end else if (cmd == pds_pkg::CMD_N_READ) begin
      cell_addr = {ncy[SW-1:0], ncx[SW-1:0]};
    end

    smp_we   = storing;
    smp_addr = sample_total[AW-1:0];
    if (cmd == pds_pkg::CMD_RD_BASE) begin
      smp_addr = act_rdata;
    end else if (cmd == pds_pkg::CMD_N_OWNER) begin
      smp_addr = cell_rdata[AW-1:0];
    end

    act_we    = storing;
    act_addr  = active_total[AW-1:0];
    act_wdata = sample_total[AW-1:0];
    if (cmd == pds_pkg::CMD_RD_ACT) begin
      act_addr = open_slot;
    end else if (cmd == pds_pkg::CMD_SHIFT_RD) begin
      act_addr = shift_inc[AW-1:0];
    end else if (cmd == pds_pkg::CMD_SHIFT_WR) begin
      act_addr  = shift_idx;
      act_we    = 1'b1;
      act_wdata = act_rdata;
    end
  end

  pds_ram #(.WIDTH(pds_pkg::CELL_DW), .DEPTH(pds_pkg::GRID_SIDE * pds_pkg::GRID_SIDE)) u_cell (
    .clk(clk), .addr(cell_addr), .we(cell_we), .wdata(cell_wdata), .rdata(cell_rdata)
  );

  pds_ram #(.WIDTH(32), .DEPTH(pds_pkg::MAX_SAMPLES)) u_smp (
    .clk(clk), .addr(smp_addr), .we(smp_we), .wdata({pt_x, pt_y}), .rdata(smp_rdata)
  );

  pds_ram #(.WIDTH(AW), .DEPTH(pds_pkg::MAX_SAMPLES)) u_act (
    .clk(clk), .addr(act_addr), .we(act_we), .wdata(act_wdata), .rdata(act_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_total <= '0;
      sample_total <= '0;
      open_slot    <= '0;
      failed       <= '0;
      step_open    <= 1'b0;
      clr_idx      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd == pds_pkg::CMD_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        pds_pkg::CMD_CLR: clr_idx <= clr_idx + pds_pkg::CELL_AW'(1);
        pds_pkg::CMD_STORE_SEED: begin
          active_total <= active_total + CW'(1);
          sample_total <= sample_total + CW'(1);
        end
        pds_pkg::CMD_STORE_CAND: begin
          active_total <= active_total + CW'(1);
          sample_total <= sample_total + CW'(1);
          step_open    <= 1'b0;
          failed       <= '0;
        end
        pds_pkg::CMD_DONE: step_open <= 1'b0;
        pds_pkg::CMD_PICK: begin
          open_slot <= pick_prod[16 +: AW];
          step_open <= 1'b1;
          failed    <= '0;
        end
        pds_pkg::CMD_TRY_FAIL: failed <= failed_next;
        pds_pkg::CMD_RETIRE: begin
          active_total <= active_total - CW'(1);
          step_open    <= 1'b0;
          failed       <= '0;
          open_slot    <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      pds_pkg::CMD_LATCH: it <= item;
      pds_pkg::CMD_LOC_SEED, pds_pkg::CMD_LOC_CAND: begin
        pt_x    <= loc_x;
        pt_y    <= loc_y;
        cxf     <= prod_x[31:22];
        cyf     <= prod_y[31:22];
        rng_bad <= (cmd == pds_pkg::CMD_LOC_CAND) && (nx[17] || nx[16] || ny[17] || ny[16]);
      end
      pds_pkg::CMD_LOAD_BASE: begin
        bx <= smp_rdata[31:16];
        by <= smp_rdata[15:0];
        nx <= $signed({2'b00, smp_rdata[31:16]}) + $signed({{2{it.offset_x[15]}}, it.offset_x});
        ny <= $signed({2'b00, smp_rdata[15:0]}) + $signed({{2{it.offset_y[15]}}, it.offset_y});
      end
      pds_pkg::CMD_SCAN_INIT: begin
        dx <= NB_MIN;
        dy <= NB_MIN;
      end
      pds_pkg::CMD_ADV: begin
        if (dx == NB_MAX) begin
          dx <= NB_MIN;
          dy <= dy + NW'(1);
        end else begin
          dx <= dx + NW'(1);
        end
      end
      pds_pkg::CMD_SQUARE: begin
        sq_x <= {16'd0, adx} * {16'd0, adx};
        sq_y <= {16'd0, ady} * {16'd0, ady};
      end
      pds_pkg::CMD_SHIFT_INIT: shift_idx <= open_slot;
      pds_pkg::CMD_SHIFT_WR:   shift_idx <= shift_idx + AW'(1);
      default: ;
    endcase

    // result being built
    case (cmd)
      pds_pkg::CMD_STORE_SEED: begin
        res_status <= pds_pkg::ST_SEEDED;
        res_fx <= pt_x; res_fy <= pt_y; res_tx <= pt_x; res_ty <= pt_y;
      end
      pds_pkg::CMD_STORE_CAND: begin
        res_status <= pds_pkg::ST_PLACED;
        res_fx <= bx; res_fy <= by; res_tx <= pt_x; res_ty <= pt_y;
      end
      pds_pkg::CMD_REJECT, pds_pkg::CMD_TRY_FAIL, pds_pkg::CMD_OUTSIDE,
      pds_pkg::CMD_DONE, pds_pkg::CMD_RETIRE: begin
        case (cmd)
          pds_pkg::CMD_OUTSIDE: res_status <= pds_pkg::ST_OUTSIDE;
          pds_pkg::CMD_DONE:    res_status <= pds_pkg::ST_DONE;
          pds_pkg::CMD_RETIRE:  res_status <= pds_pkg::ST_RETIRED;
          default:              res_status <= pds_pkg::ST_REJECTED;
        endcase
        res_fx <= '0; res_fy <= '0; res_tx <= '0; res_ty <= '0;
      end
      pds_pkg::CMD_EMIT: begin
        out_res.status           <= res_status;
        out_res.from_x           <= res_fx;
        out_res.from_y           <= res_fy;
        out_res.to_x             <= res_tx;
        out_res.to_y             <= res_ty;
        out_res.samples_stored   <= sample_total;
        out_res.active_remaining <= active_total;
      end
      default: ;
    endcase
  end

endmodule
